// File: design/idrt_pkg.sv
// ----------------------------------------------------------------------------
// idrt_pkg
// shared types and constants of the identifier remap table
// ----------------------------------------------------------------------------
package idrt_pkg;

  localparam int unsigned DefCapacity = 256;
  localparam int unsigned IdW         = 32;
  localparam int unsigned CmdW        = 2;

  // command codes, code 3 does nothing
  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2
  } idrt_cmd_e;

  // search token that walks the cell chain
  typedef struct packed {
    logic           active;
    logic           found;
    logic [IdW-1:0] query;
    logic [IdW-1:0] mapped;
  } idrt_token_t;

endpackage

// File: design/idrt_if.sv
// ----------------------------------------------------------------------------
// idrt_req_if / idrt_rsp_if
// valid/ready channels of the identifier remap table
// ----------------------------------------------------------------------------
interface idrt_req_if;
  import idrt_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [IdW-1:0]  old_id;
  logic [IdW-1:0]  new_id;

  modport source (output valid, output command, output old_id, output new_id, input ready);
  modport sink   (input valid, input command, input old_id, input new_id, output ready);
endinterface

interface idrt_rsp_if;
  import idrt_pkg::*;

  logic           valid;
  logic           ready;
  logic           found;
  logic [IdW-1:0] mapped_id;
  logic           overflow;

  modport source (output valid, output found, output mapped_id, output overflow, input ready);
  modport sink   (input valid, input found, input mapped_id, input overflow, output ready);
endinterface

// File: design/idrt_cell.sv
// ----------------------------------------------------------------------------
// idrt_cell
// one table entry with its compare, passes the search token one step on
// ----------------------------------------------------------------------------
module idrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [idrt_pkg::IdW-1:0] wr_key_i,
  input  logic [idrt_pkg::IdW-1:0] wr_value_i,
  input  logic                  valid_i,
  input  idrt_pkg::idrt_token_t tok_i,
  output idrt_pkg::idrt_token_t tok_o
);
  import idrt_pkg::*;

  logic [IdW-1:0] key_q;
  logic [IdW-1:0] value_q;
  idrt_token_t    tok_d;
  idrt_token_t    tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q   <= wr_key_i;
      value_q <= wr_value_i;
    end
  end

  // later cells are newer, so a hit here overrides an earlier one
  always_comb begin
    tok_d = tok_i;
    if (tok_i.active && valid_i && (key_q == tok_i.query)) begin
      tok_d.found  = 1'b1;
      tok_d.mapped = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: design/id_remap_table.sv
// ----------------------------------------------------------------------------
// id_remap_table
// associative old-to-new identifier table built as a chain of entry cells
// ----------------------------------------------------------------------------
// Holds up to CAPACITY (old_id, new_id) pairs, one per cell, entry k in cell
// k. A clear, an add or an unused command returns its result in the output
// register in the cycle after the transaction is accepted. A lookup sends a
// search token through the cell chain, one cell per cycle, oldest entry
// first, so a hit in a newer cell overrides an older one; its result reaches
// the output register after passing through the register of each cell.
// One command is in flight at a time: the request side is ready while no
// lookup is under way and the output register is empty or being emptied in
// the same cycle. An add on a full table is dropped and reported with
// overflow. There is no clearing pass after reset: only entries below the
// fill count are ever compared.
// ----------------------------------------------------------------------------
module id_remap_table #(
  parameter int unsigned CAPACITY = idrt_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  idrt_req_if.sink      req_i,
  idrt_rsp_if.source    rsp_o
);
  import idrt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // fill count, number of valid entries
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  // lookup under way in the chain
  logic busy_q;
  logic busy_d;

  // output register
  logic           out_valid_q;
  logic           out_valid_d;
  logic           found_q;
  logic           found_d;
  logic [IdW-1:0] mapped_q;
  logic [IdW-1:0] mapped_d;
  logic           overflow_q;
  logic           overflow_d;

  logic req_fire;
  logic is_clear;
  logic is_add;
  logic is_lookup;
  logic full;
  logic add_fire;

  idrt_token_t           tok [CAPACITY+1];
  logic [CAPACITY-1:0]   cell_wr;
  logic [CAPACITY-1:0]   cell_valid;
  idrt_token_t           tail;

  // handshake: one command at a time, output register must be free
  assign req_i.ready = !busy_q && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign is_clear  = (req_i.command == CMD_CLEAR);
  assign is_add    = (req_i.command == CMD_ADD);
  assign is_lookup = (req_i.command == CMD_LOOKUP);
  assign full      = (count_q == CntW'(CAPACITY));
  assign add_fire  = req_fire && is_add && !full;

  // search token enters the first cell in the accept cycle
  assign tok[0] = '{active: req_fire && is_lookup,
                    found:  1'b0,
                    query:  req_i.old_id,
                    mapped: '0};

  // cell chain, write goes to the cell at the fill count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_wr[i]    = add_fire && (count_q == CntW'(i));
    assign cell_valid[i] = (CntW'(i) < count_q);

    idrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (cell_wr[i]),
      .wr_key_i   (req_i.old_id),
      .wr_value_i (req_i.new_id),
      .valid_i    (cell_valid[i]),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  assign tail = tok[CAPACITY];

  // fill count and busy flag
  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    if (req_fire && is_clear) begin
      count_d = '0;
    end else if (add_fire) begin
      count_d = count_q + CntW'(1);
    end
    if (req_fire && is_lookup) begin
      busy_d = 1'b1;
    end else if (tail.active) begin
      busy_d = 1'b0;
    end
  end

  // output register, loaded at accept for non-lookups, at chain exit for lookups
  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    mapped_d    = mapped_q;
    overflow_d  = overflow_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (tail.active) begin
      out_valid_d = 1'b1;
      found_d     = tail.found;
      mapped_d    = tail.found ? tail.mapped : '0;
      overflow_d  = 1'b0;
    end else if (req_fire && !is_lookup) begin
      out_valid_d = 1'b1;
      found_d     = 1'b0;
      mapped_d    = '0;
      overflow_d  = is_add && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    mapped_q   <= mapped_d;
    overflow_q <= overflow_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.mapped_id = mapped_q;
  assign rsp_o.overflow  = overflow_q;

  // fill count never passes the capacity
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // a token leaves the chain only for the lookup in flight
  a_tail_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |-> busy_q)
    else $error("search token without a pending lookup");

  // output register stays empty while a lookup walks the chain
  a_busy_out_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("result pending during a lookup");

  // a dropped add never reports a hit
  a_overflow_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && overflow_q) |-> (!found_q && (mapped_q == '0)))
    else $error("overflow result carries a hit");

endmodule
